### design/polygon_area_centroid_macros.svh
// ----------------------------------------------------------------------------
// Polygon area and centroid assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_CENTROID_MACROS_SVH
`define POLYGON_AREA_CENTROID_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pac_pkg.sv
// ----------------------------------------------------------------------------
// Polygon area and centroid package
// Word types, edge queue entry and fixed widths shared by the block.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int COORD_W              = 16;
  localparam int AREA_W               = 43;
  localparam int MOM_W                = 61;
  localparam int OUT_AREA_W           = 42;
  localparam int CROSS_W              = 2 * COORD_W + 1;
  localparam int PROD_W               = CROSS_W + COORD_W + 1;
  localparam int DIVISOR_W            = AREA_W + 2;
  localparam int QUEUE_DEPTH          = 4;
  localparam int DEFAULT_MAX_VERTICES = 1024;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_AREA_W-1:0] double_signed_area;
    logic        [OUT_AREA_W-1:0] area_magnitude;
    logic signed [COORD_W-1:0]    centroid_x;
    logic signed [COORD_W-1:0]    centroid_y;
    logic                         degenerate;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic                      close;
    logic                      few;
  } edge_t;

endpackage

### design/polygon_area_centroid.sv
// Sequence: edges go one at a time through S_CR1, S_CR2, S_MX, S_AX and S_AY.
// Throughput: one vertex a cycle into a 4-word edge queue while it has room and no
// closing edge waits; the last vertex adds one; S_FIN, any S_DIV and S_OUT finish.
// Reset: synchronous active-low rst_n clears control state and the sums.
// ----------------------------------------------------------------------------
// Polygon area and centroid
// Shoelace twice-area and centroid of a streamed polygon.
// ----------------------------------------------------------------------------
module polygon_area_centroid #(
  parameter int MAX_VERTICES = pac_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pac_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pac_pkg::out_word_t out_data
);

  logic           push, q_full, pop, q_valid;
  pac_pkg::edge_t push_data, q_data;

  pac_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  pac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  pac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/pac_front.sv
// ----------------------------------------------------------------------------
// Polygon area and centroid front end
// Accepts vertices and turns them into edges, closing the ring on the last one.
// ----------------------------------------------------------------------------
module pac_front #(
  parameter int MAX_VERTICES = pac_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pac_pkg::in_word_t in_data,
  output logic             push,
  output pac_pkg::edge_t   push_data,
  input  logic             q_full
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic signed [pac_pkg::COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_r;
  pac_pkg::edge_t   pend_edge_r;
  logic             accept, drop;
  pac_pkg::edge_t   cur_edge;

  assign in_ready = !pend_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign drop     = !in_data.last_vertex && (cnt_r >= CNT_W'(MAX_VERTICES - 1));

  always_comb begin
    cur_edge.x1    = (cnt_r == '0) ? in_data.vertex_x : prev_x_r;
    cur_edge.y1    = (cnt_r == '0) ? in_data.vertex_y : prev_y_r;
    cur_edge.x2    = in_data.vertex_x;
    cur_edge.y2    = in_data.vertex_y;
    cur_edge.close = (cnt_r == '0) && in_data.last_vertex;
    cur_edge.few   = 1'b1;
  end

  always_comb begin
    push      = 1'b0;
    push_data = pend_edge_r;
    if (pend_r) begin
      push = !q_full;
    end else if (accept && !drop && (cnt_r != '0 || in_data.last_vertex)) begin
      push      = 1'b1;
      push_data = cur_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (pend_r && !q_full) begin
        pend_r <= 1'b0;
      end
      if (accept && !drop) begin
        prev_x_r <= in_data.vertex_x;
        prev_y_r <= in_data.vertex_y;
        if (cnt_r == '0) begin
          first_x_r <= in_data.vertex_x;
          first_y_r <= in_data.vertex_y;
        end
        if (in_data.last_vertex) begin
          cnt_r <= '0;
          if (cnt_r != '0) begin
            pend_r <= 1'b1;
          end
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop && in_data.last_vertex) begin
      pend_edge_r.x1    <= in_data.vertex_x;
      pend_edge_r.y1    <= in_data.vertex_y;
      pend_edge_r.x2    <= first_x_r;
      pend_edge_r.y2    <= first_y_r;
      pend_edge_r.close <= 1'b1;
      pend_edge_r.few   <= (cnt_r < CNT_W'(2));
    end
  end

endmodule

### design/pac_queue.sv
// ----------------------------------------------------------------------------
// Polygon area and centroid edge queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module pac_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pac_pkg::edge_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output pac_pkg::edge_t q_data
);

  localparam int PTR_W = $clog2(pac_pkg::QUEUE_DEPTH);

  pac_pkg::edge_t mem_r [pac_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PTR_W+1)'(pac_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/pac_div.sv
// ----------------------------------------------------------------------------
// Polygon area and centroid divider
// Restoring signed division, one quotient bit a cycle, saturated result.
// ----------------------------------------------------------------------------
module pac_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pac_pkg::MOM_W-1:0]     dividend,
  input  logic signed [pac_pkg::DIVISOR_W-1:0] divisor,
  output logic                                done,
  output logic signed [pac_pkg::COORD_W-1:0]   quotient
);

  localparam int MW    = pac_pkg::MOM_W;
  localparam int DW    = pac_pkg::DIVISOR_W;
  localparam int CW    = pac_pkg::COORD_W;
  localparam int STEPW = $clog2(MW);

  logic            busy_r, done_r, neg_r;
  logic [STEPW-1:0] step_r;
  logic [DW:0]     rem_r;
  logic [MW-1:0]   quo_r;
  logic [DW-1:0]   dvs_r;
  logic [DW:0]     trial;
  logic            fits;
  logic [MW-1:0]   quo_nxt;
  logic signed [CW-1:0] quotient_r;

  assign trial   = {rem_r[DW-1:0], quo_r[MW-1]};
  assign fits    = (trial >= {1'b0, dvs_r});
  assign quo_nxt = {quo_r[MW-2:0], fits};
  assign done     = done_r;
  assign quotient = quotient_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEPW'(MW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[MW-1] ? MW'(-dividend) : MW'(dividend);
      dvs_r <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
      neg_r <= dividend[MW-1] ^ divisor[DW-1];
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, dvs_r}) : trial;
      quo_r <= quo_nxt;
      if (step_r == STEPW'(MW - 1)) begin
        if (!neg_r) begin
          quotient_r <= (quo_nxt > MW'((1 << (CW - 1)) - 1)) ?
                        CW'((1 << (CW - 1)) - 1) : CW'(quo_nxt);
        end else begin
          quotient_r <= (quo_nxt > MW'(1 << (CW - 1))) ?
                        CW'(1 << (CW - 1)) : CW'(-quo_nxt);
        end
      end
    end
  end

endmodule

### design/pac_back.sv
// ----------------------------------------------------------------------------
// Polygon area and centroid back end
// Accumulates shoelace sums per edge and finishes each polygon.
// ----------------------------------------------------------------------------
module pac_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pac_pkg::edge_t    q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pac_pkg::out_word_t out_data
);

  localparam int CW = pac_pkg::COORD_W;
  localparam int AW = pac_pkg::AREA_W;
  localparam int OW = pac_pkg::OUT_AREA_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CR1  = 9'b000000010,
    S_CR2  = 9'b000000100,
    S_MX   = 9'b000001000,
    S_AX   = 9'b000010000,
    S_AY   = 9'b000100000,
    S_FIN  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  pac_pkg::edge_t edge_r;
  logic signed [2*CW-1:0]             p_r;
  logic signed [pac_pkg::CROSS_W-1:0] cr_r;
  logic signed [pac_pkg::PROD_W-1:0]  prod_r;
  logic signed [AW-1:0]               area_r;
  logic signed [pac_pkg::MOM_W-1:0]   mx_r, my_r;
  logic signed [CW:0]                 sx, sy;
  logic signed [OW-1:0]               dsa;
  logic [OW-1:0]                      mag;
  logic                               degen;
  logic signed [pac_pkg::DIVISOR_W-1:0] divisor;
  logic                               div_start, done_x, done_y;
  logic signed [CW-1:0]               qx, qy;
  logic                               out_valid_r;
  pac_pkg::out_word_t                 res_r, out_r;

  assign sx = (CW+1)'(edge_r.x1) + (CW+1)'(edge_r.x2);
  assign sy = (CW+1)'(edge_r.y1) + (CW+1)'(edge_r.y2);
  assign pop       = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (area_r[AW-1] != area_r[AW-2]) begin
      dsa = area_r[AW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end else begin
      dsa = OW'(area_r);
    end
    mag       = dsa[OW-1] ? OW'(-dsa) : OW'(dsa);
    degen     = (area_r == '0) || edge_r.few;
    divisor   = pac_pkg::DIVISOR_W'(area_r) + (pac_pkg::DIVISOR_W'(area_r) <<< 1);
    div_start = (state_r == S_FIN) && !degen;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_CR1;
      S_CR1:  state_nxt = S_CR2;
      S_CR2:  state_nxt = S_MX;
      S_MX:   state_nxt = S_AX;
      S_AX:   state_nxt = S_AY;
      S_AY:   state_nxt = edge_r.close ? S_FIN : S_IDLE;
      S_FIN:  state_nxt = degen ? S_OUT : S_DIV;
      S_DIV:  if (done_x && done_y) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      area_r      <= '0;
      mx_r        <= '0;
      my_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_MX) begin
        area_r <= area_r + AW'(cr_r);
      end
      if (state_r == S_AX) begin
        mx_r <= mx_r + pac_pkg::MOM_W'(prod_r);
      end
      if (state_r == S_AY) begin
        my_r <= my_r + pac_pkg::MOM_W'(prod_r);
      end
      if (state_r == S_FIN) begin
        area_r <= '0;
        mx_r   <= '0;
        my_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      edge_r <= q_data;
    end
    if (state_r == S_CR1) begin
      p_r <= edge_r.x1 * edge_r.y2;
    end
    if (state_r == S_CR2) begin
      cr_r <= pac_pkg::CROSS_W'(p_r) - pac_pkg::CROSS_W'(edge_r.x2 * edge_r.y1);
    end
    if (state_r == S_MX) begin
      prod_r <= sx * cr_r;
    end
    if (state_r == S_AX) begin
      prod_r <= sy * cr_r;
    end
    if (state_r == S_FIN) begin
      res_r.double_signed_area <= dsa;
      res_r.area_magnitude     <= mag;
      res_r.centroid_x         <= '0;
      res_r.centroid_y         <= '0;
      res_r.degenerate         <= degen;
    end
    if (state_r == S_DIV && done_x && done_y) begin
      res_r.centroid_x <= qx;
      res_r.centroid_y <= qy;
    end
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

  pac_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mx_r),
    .divisor  (divisor),
    .done     (done_x),
    .quotient (qx)
  );

  pac_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (my_r),
    .divisor  (divisor),
    .done     (done_y),
    .quotient (qy)
  );

endmodule

### design/pac_checker.sv
// ----------------------------------------------------------------------------
// Polygon area and centroid checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "polygon_area_centroid_macros.svh"

module pac_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pac_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pac_pkg::out_word_t out_data
);

  `PAC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "in word dropped")
  `PAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out word dropped")
  `PAC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "out word changed")
  `PAC_ASSERT_NOW(a_mag, out_valid, out_data.area_magnitude == (out_data.double_signed_area[41] ? 42'(-out_data.double_signed_area) : 42'(out_data.double_signed_area)), "magnitude mismatch")
  `PAC_ASSERT_NOW(a_degen, out_valid && out_data.degenerate, out_data.centroid_x == 16'sd0 && out_data.centroid_y == 16'sd0, "degenerate centroid nonzero")

endmodule

bind polygon_area_centroid pac_checker u_pac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
